/* design/cbrf_pkg.sv */
`timescale 1ns / 1ps

package cbrf_pkg;

    // Ring buffer geometry
    localparam int DEPTH     = 16;
    localparam int PTR_W     = $clog2(DEPTH);

    // Field widths
    localparam int TYPE_W    = 16;
    localparam int CHAN_W    = 16;
    localparam int CODE_W    = 16;
    localparam int DATA_W    = 32;
    localparam int HDR_W     = TYPE_W + CHAN_W + CODE_W;

    // Front command queue and result queue sizes
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_CODE = 1'd1;
    localparam int CFG_DATA_W = 16;

    // Classified command word, front to back
    typedef struct packed {
        logic              is_commit;
        logic [TYPE_W-1:0] cmd_type;
        logic [CHAN_W-1:0] cmd_channel;
        logic [CODE_W-1:0] cmd_code;
        logic [DATA_W-1:0] cmd_data;
    } t_cmd;

    // Drained result word
    typedef struct packed {
        logic [TYPE_W-1:0] out_type;
        logic [CHAN_W-1:0] out_channel;
        logic [CODE_W-1:0] out_code;
        logic [DATA_W-1:0] out_data;
        logic              is_last;
    } t_res;

    // Back-end status
    typedef struct packed {
        logic draining;
        logic buf_empty;
    } t_back_stat;

    // Ring pointer advance, modulo DEPTH
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

/* design/cbrf_ram.sv */
`timescale 1ns / 1ps

module cbrf_ram #(
    parameter int WIDTH   = 32,
    parameter int DEPTH_P = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH_P)-1:0] i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH_P)-1:0] i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH_P];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/cbrf_front.sv */
`timescale 1ns / 1ps

module cbrf_front
    import cbrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [TYPE_W-1:0]     i_cmd_type,
    input  logic [CHAN_W-1:0]     i_cmd_channel,
    input  logic [CODE_W-1:0]     i_cmd_code,
    input  logic [DATA_W-1:0]     i_cmd_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_pop
);

    logic [TYPE_W-1:0]   r_commit_type;
    logic [CODE_W-1:0]   r_commit_code;
    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic [CQ_PTR_W-1:0] n_wp;
    logic [CQ_PTR_W-1:0] n_rp;
    logic [CQ_CNT_W-1:0] n_cnt;
    logic                wr_en;
    logic                rd_en;
    t_cmd                cmd_in;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_type <= '0;
            r_commit_code <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COMMIT_TYPE: r_commit_type <= i_cfg_wdata[TYPE_W-1:0];
                CFG_COMMIT_CODE: r_commit_code <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the incoming word
    always_comb begin
        cmd_in.is_commit   = (i_cmd_type == r_commit_type) && (i_cmd_code == r_commit_code);
        cmd_in.cmd_type    = i_cmd_type;
        cmd_in.cmd_channel = i_cmd_channel;
        cmd_in.cmd_code    = i_cmd_code;
        cmd_in.cmd_data    = i_cmd_data;
    end

    assign o_full      = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    // Queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wp + CQ_PTR_W'(1);
        end
        if (rd_en) begin
            n_rp = (r_rp == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rp + CQ_PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CQ_CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

/* design/cbrf_back.sv */
`timescale 1ns / 1ps

module cbrf_back
    import cbrf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    input  logic [OQ_CNT_W-1:0] i_oq_count,
    output logic                o_res_valid,
    output t_res                o_res,
    output t_back_stat          o_stat
);

    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic              r_buf_empty;
    logic              r_draining;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic              n_buf_empty;
    logic              n_draining;
    logic              n_rd_last;
    logic [PTR_W-1:0]  rd_next;
    logic [OQ_CNT_W:0] oq_used;
    logic              room;
    logic              issue;
    logic              do_push;
    logic              start;
    logic [HDR_W-1:0]  hdr_rdata;
    logic [DATA_W-1:0] pay_rdata;

    // Result queue space, counting the read already in flight
    assign oq_used = {1'b0, i_oq_count} + {{OQ_CNT_W{1'b0}}, r_rd_valid};
    assign room    = oq_used < (OQ_CNT_W + 1)'(OQ_DEPTH);

    assign rd_next   = next_slot(r_rd_ptr);
    assign issue     = r_draining && room;
    assign o_cmd_pop = !r_draining && i_cmd_valid;
    assign do_push   = o_cmd_pop && !i_cmd.is_commit;
    assign start     = o_cmd_pop && i_cmd.is_commit && !r_buf_empty;

    // Ring pointer and drain control
    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_buf_empty = r_buf_empty;
        n_draining  = r_draining;
        n_rd_last   = r_rd_last;
        if (do_push) begin
            n_wr_ptr    = next_slot(r_wr_ptr);
            n_buf_empty = 1'b0;
            // full ring: drop the oldest word
            if (!r_buf_empty && (r_wr_ptr == r_rd_ptr)) begin
                n_rd_ptr = rd_next;
            end
        end
        if (start) begin
            n_draining = 1'b1;
        end
        if (issue) begin
            n_rd_ptr  = rd_next;
            n_rd_last = (rd_next == r_wr_ptr);
            if (rd_next == r_wr_ptr) begin
                n_buf_empty = 1'b1;
                n_draining  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_buf_empty <= 1'b1;
            r_draining  <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_buf_empty <= n_buf_empty;
            r_draining  <= n_draining;
            r_rd_valid  <= issue;
        end
    end

    // Last flag travels with the read
    always_ff @(posedge i_clk) begin
        r_rd_last <= n_rd_last;
    end

    // Header and payload stores
    cbrf_ram #(
        .WIDTH   (HDR_W),
        .DEPTH_P (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wr_ptr),
        .i_wdata ({i_cmd.cmd_type, i_cmd.cmd_channel, i_cmd.cmd_code}),
        .i_re    (issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (hdr_rdata)
    );

    cbrf_ram #(
        .WIDTH   (DATA_W),
        .DEPTH_P (DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.cmd_data),
        .i_re    (issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (pay_rdata)
    );

    // Result word
    always_comb begin
        o_res.out_type    = hdr_rdata[HDR_W-1 -: TYPE_W];
        o_res.out_channel = hdr_rdata[CHAN_W+CODE_W-1 -: CHAN_W];
        o_res.out_code    = hdr_rdata[CODE_W-1:0];
        o_res.out_data    = pay_rdata;
        o_res.is_last     = r_rd_last;
    end

    assign o_res_valid     = r_rd_valid;
    assign o_stat.draining  = r_draining;
    assign o_stat.buf_empty = r_buf_empty;

endmodule

/* design/cbrf_outq.sv */
`timescale 1ns / 1ps

module cbrf_outq
    import cbrf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  t_res                i_res,
    input  logic                i_pop,
    output logic                o_empty,
    output t_res                o_res,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_res                r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign o_count = r_cnt;
    assign rd_en   = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wp + OQ_PTR_W'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rp + OQ_PTR_W'(1);
            end
            if (i_wr && !rd_en) begin
                r_cnt <= r_cnt + OQ_CNT_W'(1);
            end else if (rd_en && !i_wr) begin
                r_cnt <= r_cnt - OQ_CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

/* design/command_batch_ring_fifo.sv */
// A stored word goes from the front queue into the ring; the first word of a commit
// batch passes the front queue, drain flag, ring read register and result queue to
// the result ports, when nothing waits ahead of it in the front queue.
// Throughput: one input word per cycle while full is low; a batch drains one word
// per cycle from the ring memory read port while the result queue has room.
// Reset (synchronous, active low) empties the ring, both queues and clears the
// commit codes; the ring memories themselves are not cleared.
`timescale 1ns / 1ps

module command_batch_ring_fifo
    import cbrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [TYPE_W-1:0]     i_cmd_type,
    input  logic [CHAN_W-1:0]     i_cmd_channel,
    input  logic [CODE_W-1:0]     i_cmd_code,
    input  logic [DATA_W-1:0]     i_cmd_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [TYPE_W-1:0]     o_out_type,
    output logic [CHAN_W-1:0]     o_out_channel,
    output logic [CODE_W-1:0]     o_out_code,
    output logic [DATA_W-1:0]     o_out_data,
    output logic                  o_is_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic                w_cmd_valid;
    t_cmd                w_cmd;
    logic                w_cmd_pop;
    logic                w_res_valid;
    t_res                w_res;
    t_res                w_out;
    t_back_stat          w_stat;
    logic [OQ_CNT_W-1:0] w_oq_count;

    // Accept and classify
    cbrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd_type    (i_cmd_type),
        .i_cmd_channel (i_cmd_channel),
        .i_cmd_code    (i_cmd_code),
        .i_cmd_data    (i_cmd_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    // Ring buffer and drain
    cbrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_oq_count  (w_oq_count),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    // Result queue
    cbrf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_res   (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_out),
        .o_count (w_oq_count)
    );

    assign o_out_type    = w_out.out_type;
    assign o_out_channel = w_out.out_channel;
    assign o_out_code    = w_out.out_code;
    assign o_out_data    = w_out.out_data;
    assign o_is_last     = w_out.is_last;

`ifndef SYNTHESIS
    // Result queue never overflows
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_oq_count < OQ_CNT_W'(OQ_DEPTH)))
        else $error("result queue overflow");

    // Last word of a batch ends the drain and leaves the ring empty
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.is_last) |-> (!w_stat.draining && w_stat.buf_empty))
        else $error("drain still active after last word");

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
